[sv/ikst_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the IPC key slot table.
// Used by ikst_ctrl, ikst_dp and ipc_key_slot_table; depends on nothing.
package ikst_pkg;

    localparam int SLOTS      = 64;
    localparam int KEY_BITS   = 32;
    localparam int IDX_W      = $clog2(SLOTS);
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int SEQ_W      = 32;
    localparam int KEY_OUT_W  = 32;
    localparam int ROOM_W     = 16;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 4;

    localparam int IN_FIELDS_W  = KEY_BITS + 3 + IDX_W + ROOM_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = IDX_W + SEQ_W + KEY_OUT_W + CNT_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_GET    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_QUERY  = 2'd2,
        KIND_LIST   = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_FOUND        = 4'd0,
        STAT_CREATED      = 4'd1,
        STAT_EXISTS       = 4'd2,
        STAT_NOT_FOUND    = 4'd3,
        STAT_NO_SPACE     = 4'd4,
        STAT_CONSTRUCT_NG = 4'd5,
        STAT_REMOVED      = 4'd6,
        STAT_ABSENT       = 4'd7,
        STAT_LIST_ITEM    = 4'd8,
        STAT_LIST_NONE    = 4'd9
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_GET_END,
        ST_PROBE_END,
        ST_LIST,
        ST_NONE
    } state_t;

    // Input tdata layout, lowest field last.
    typedef struct packed {
        logic [IN_DATA_W-IN_FIELDS_W-1:0] pad;
        logic [ROOM_W-1:0]                list_room;
        logic [IDX_W-1:0]                 slot;
        logic                             construct_ok;
        logic                             exclusive;
        logic                             create;
        logic [KEY_BITS-1:0]              key;
    } in_data_t;

    // Output tdata layout, lowest field last.
    typedef struct packed {
        logic [OUT_DATA_W-OUT_FIELDS_W-1:0] pad;
        logic [CNT_W-1:0]                   used;
        logic [KEY_OUT_W-1:0]               slot_key;
        logic [SEQ_W-1:0]                   seq;
        logic [IDX_W-1:0]                   slot_id;
    } out_data_t;

    typedef struct packed {
        kind_t               kind;
        logic [KEY_BITS-1:0] key;
        logic                create;
        logic                exclusive;
        logic                construct_ok;
        logic [IDX_W-1:0]    slot;
        logic [ROOM_W-1:0]   list_room;
    } req_t;

    typedef struct packed {
        status_t              status;
        logic [IDX_W-1:0]     slot_id;
        logic [SEQ_W-1:0]     seq;
        logic [KEY_OUT_W-1:0] slot_key;
        logic [CNT_W-1:0]     used;
        logic                 last;
    } rsp_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic scan_clr;
        logic scan_run;
        logic list_run;
        logic probe_rd;
        logic get_fin;
        logic probe_fin;
        logic none_emit;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        kind_t kind;
        logic  key_zero;
        logic  list_ok;
        logic  scan_done;
        logic  list_last;
        logic  out_free;
    } stat_t;

endpackage

[sv/ikst_ctrl.sv]
`timescale 1ns / 1ps
// Sequencing state machine of the IPC key slot table.
// Depends on ikst_pkg; drives the command struct of ikst_dp.
module ikst_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  ikst_pkg::stat_t stat,
    output ikst_pkg::cmd_t  cmd
);
    import ikst_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                cmd.scan_clr = 1'b1;
                case (stat.kind)
                    KIND_GET: begin
                        state_next = stat.key_zero ? ST_GET_END : ST_SCAN;
                    end
                    KIND_REMOVE, KIND_QUERY: begin
                        cmd.probe_rd = 1'b1;
                        state_next   = ST_PROBE_END;
                    end
                    KIND_LIST: begin
                        state_next = stat.list_ok ? ST_LIST : ST_NONE;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_SCAN: begin
                cmd.scan_run = 1'b1;
                if (stat.scan_done) begin
                    state_next = ST_GET_END;
                end
            end
            ST_GET_END: begin
                if (stat.out_free) begin
                    cmd.get_fin = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_PROBE_END: begin
                if (stat.out_free) begin
                    cmd.probe_fin = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_LIST: begin
                cmd.list_run = 1'b1;
                if (stat.list_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_NONE: begin
                if (stat.out_free) begin
                    cmd.none_emit = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[sv/ikst_dp.sv]
`timescale 1ns / 1ps
// Datapath of the IPC key slot table: slot stores, scan pipeline, output register.
// Depends on ikst_pkg; commanded by ikst_ctrl.
module ikst_dp (
    input  logic            aclk,
    input  logic            aresetn,
    input  ikst_pkg::req_t  req_in,
    input  ikst_pkg::cmd_t  cmd,
    input  logic            out_ready,
    output ikst_pkg::stat_t stat,
    output logic            out_valid,
    output ikst_pkg::rsp_t  out_rsp
);
    import ikst_pkg::*;

    logic [KEY_BITS-1:0] key_mem [SLOTS];
    logic [SEQ_W-1:0]    seq_mem [SLOTS];

    req_t                req_reg;
    logic [SLOTS-1:0]    vld_reg, vld_next;
    logic [CNT_W-1:0]    hw_reg, hw_next;
    logic [CNT_W-1:0]    used_reg, used_next;
    logic [SEQ_W-1:0]    seq_reg, seq_next;

    logic [CNT_W-1:0]    sp_reg, sp_next;
    logic                pv_reg, pv_next;
    logic [IDX_W-1:0]    pidx_reg, pidx_next;
    logic [KEY_BITS-1:0] krd_reg;
    logic [SEQ_W-1:0]    srd_reg;
    logic                hit_reg, hit_next;
    logic [IDX_W-1:0]    hit_idx_reg, hit_idx_next;
    logic [SEQ_W-1:0]    hit_seq_reg, hit_seq_next;
    logic [CNT_W-1:0]    pick_reg, pick_next;
    logic                pick_set_reg, pick_set_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                ovld_reg, ovld_next;
    rsp_t                orsp_reg, orsp_next;

    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;
    logic [CNT_W-1:0]    pick_fin;
    logic                out_free, cur_vld, pipe_item, adv, issue;
    logic                key_zero, create_eff, present, item_last;

    always_comb begin
        out_free   = !ovld_reg || out_ready;
        cur_vld    = vld_reg[pidx_reg];
        pipe_item  = pv_reg && cur_vld;
        key_zero   = (req_reg.key == '0);
        create_eff = req_reg.create || key_zero;
        pick_fin   = pick_set_reg ? pick_reg : hw_reg;
        present    = (CNT_W'(req_reg.slot) < hw_reg) && vld_reg[req_reg.slot];
        item_last  = pipe_item && out_free && ((cnt_reg + 1'b1) == used_reg);

        // stall the list pipeline while an item waits on a full output register
        adv     = cmd.scan_run || (cmd.list_run && !(pipe_item && !out_free));
        issue   = adv && (sp_reg < hw_reg) && !(cmd.scan_run && hit_reg);
        rd_en   = issue || cmd.probe_rd;
        rd_addr = cmd.probe_rd ? req_reg.slot : sp_reg[IDX_W-1:0];
        wr_en   = 1'b0;

        vld_next      = vld_reg;
        hw_next       = hw_reg;
        used_next     = used_reg;
        seq_next      = seq_reg;
        sp_next       = sp_reg;
        pv_next       = pv_reg;
        pidx_next     = pidx_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        hit_seq_next  = hit_seq_reg;
        pick_next     = pick_reg;
        pick_set_next = pick_set_reg;
        cnt_next      = cnt_reg;
        ovld_next     = ovld_reg && !out_ready;
        orsp_next     = orsp_reg;

        if (cmd.scan_clr) begin
            sp_next       = '0;
            pv_next       = 1'b0;
            hit_next      = 1'b0;
            pick_set_next = 1'b0;
            cnt_next      = '0;
        end

        if (adv) begin
            pv_next   = issue;
            pidx_next = sp_reg[IDX_W-1:0];
            if (issue) begin
                sp_next = sp_reg + 1'b1;
            end
        end

        // key search: first match wins, note the first free slot before it
        if (cmd.scan_run && pv_reg && !hit_reg) begin
            if (cur_vld && (krd_reg == req_reg.key)) begin
                hit_next     = 1'b1;
                hit_idx_next = pidx_reg;
                hit_seq_next = srd_reg;
            end else if (!cur_vld && !pick_set_reg) begin
                pick_next     = CNT_W'(pidx_reg);
                pick_set_next = 1'b1;
            end
        end

        if (cmd.list_run && pipe_item && out_free) begin
            cnt_next  = cnt_reg + 1'b1;
            ovld_next = 1'b1;
            orsp_next = '{STAT_LIST_ITEM, pidx_reg, srd_reg, KEY_OUT_W'(krd_reg),
                          used_reg, item_last};
        end

        if (cmd.get_fin) begin
            ovld_next = 1'b1;
            orsp_next = '{STAT_NOT_FOUND, '0, '0, KEY_OUT_W'(req_reg.key), used_reg, 1'b1};
            if (hit_reg) begin
                orsp_next.status  = (req_reg.create && req_reg.exclusive) ?
                                    STAT_EXISTS : STAT_FOUND;
                orsp_next.slot_id = hit_idx_reg;
                orsp_next.seq     = hit_seq_reg;
            end else if (!create_eff) begin
                orsp_next.status = STAT_NOT_FOUND;
            end else if (!req_reg.construct_ok) begin
                orsp_next.status = STAT_CONSTRUCT_NG;
            end else if (pick_fin >= CNT_W'(SLOTS)) begin
                orsp_next.status = STAT_NO_SPACE;
            end else begin
                wr_en                             = 1'b1;
                vld_next[pick_fin[IDX_W-1:0]]     = 1'b1;
                seq_next                          = seq_reg + 1'b1;
                used_next                         = used_reg + 1'b1;
                if (pick_fin == hw_reg) begin
                    hw_next = hw_reg + 1'b1;
                end
                orsp_next.status  = STAT_CREATED;
                orsp_next.slot_id = pick_fin[IDX_W-1:0];
                orsp_next.seq     = seq_reg;
                orsp_next.used    = used_reg + 1'b1;
            end
        end

        if (cmd.probe_fin) begin
            ovld_next = 1'b1;
            if (!present) begin
                orsp_next = '{STAT_ABSENT, '0, '0, '0, used_reg, 1'b1};
            end else if (req_reg.kind == KIND_REMOVE) begin
                vld_next[req_reg.slot] = 1'b0;
                used_next              = used_reg - 1'b1;
                orsp_next = '{STAT_REMOVED, req_reg.slot, srd_reg, KEY_OUT_W'(krd_reg),
                              used_reg - 1'b1, 1'b1};
            end else begin
                orsp_next = '{STAT_FOUND, req_reg.slot, srd_reg, KEY_OUT_W'(krd_reg),
                              used_reg, 1'b1};
            end
        end

        if (cmd.none_emit) begin
            ovld_next = 1'b1;
            orsp_next = '{STAT_LIST_NONE, '0, '0, '0, used_reg, 1'b1};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            hw_reg       <= '0;
            used_reg     <= '0;
            seq_reg      <= '0;
            sp_reg       <= '0;
            pv_reg       <= 1'b0;
            hit_reg      <= 1'b0;
            pick_set_reg <= 1'b0;
            cnt_reg      <= '0;
            ovld_reg     <= 1'b0;
        end else begin
            vld_reg      <= vld_next;
            hw_reg       <= hw_next;
            used_reg     <= used_next;
            seq_reg      <= seq_next;
            sp_reg       <= sp_next;
            pv_reg       <= pv_next;
            hit_reg      <= hit_next;
            pick_set_reg <= pick_set_next;
            cnt_reg      <= cnt_next;
            ovld_reg     <= ovld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg <= req_in;
        end
        pidx_reg    <= pidx_next;
        hit_idx_reg <= hit_idx_next;
        hit_seq_reg <= hit_seq_next;
        pick_reg    <= pick_next;
        orsp_reg    <= orsp_next;
    end

    // slot stores: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[pick_fin[IDX_W-1:0]] <= req_reg.key;
            seq_mem[pick_fin[IDX_W-1:0]] <= seq_reg;
        end
        if (rd_en) begin
            krd_reg <= key_mem[rd_addr];
            srd_reg <= seq_mem[rd_addr];
        end
    end

    always_comb begin
        stat.kind      = req_reg.kind;
        stat.key_zero  = key_zero;
        stat.list_ok   = (req_reg.list_room >= ROOM_W'(used_reg)) && (used_reg != '0);
        stat.scan_done = hit_reg || ((sp_reg >= hw_reg) && !pv_reg);
        stat.list_last = item_last;
        stat.out_free  = out_free;
    end

    assign out_valid = ovld_reg;
    assign out_rsp   = orsp_reg;

endmodule

[sv/ipc_key_slot_table.sv]
`timescale 1ns / 1ps
// IPC key slot table: maps keys to slot ids over a fixed table of SLOTS slots.
// Top level; depends on ikst_pkg, ikst_ctrl and ikst_dp.
//
// Usage:
//   Requests arrive on the s_ stream; s_tuser carries the request kind (get,
//   remove, query, list) and s_tdata the key, flags, slot and list room.
//   Results leave on the m_ stream; m_tuser carries the status, m_tdata the
//   slot id, sequence stamp, key and used count, m_tlast the end of a run.
//   Every request yields one result except a list, which yields one result
//   per valid slot in ascending order (or a single list_none).
//   One request is in flight at a time; s_tready is high only while idle.
//   Timing: a get scans one slot per cycle below the high-water mark; a list
//   streams one slot per cycle while the output register is not stalled.
//   The scan rate is set by the single read port of the key and sequence stores.
//   Results sit in an output register; when the receiver stalls, a list holds
//   in place and a finished get, remove or query waits for the register, then
//   all resume with no transaction lost.
//   Reset clears the valid bits, counters and output register at once; no
//   clearing pass is needed, and the block accepts a request in the next cycle.
module ipc_key_slot_table (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // fields from bit 0: key, create, exclusive, construct_ok, slot, list_room
    input  logic [ikst_pkg::IN_DATA_W-1:0]  s_tdata,
    // fields from bit 0: kind
    input  logic [ikst_pkg::KIND_W-1:0]     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // fields from bit 0: slot_id, seq, slot_key, used
    output logic [ikst_pkg::OUT_DATA_W-1:0] m_tdata,
    // fields from bit 0: status
    output logic [ikst_pkg::STATUS_W-1:0]   m_tuser,
    output logic                           m_tlast
);
    import ikst_pkg::*;

    in_data_t  in_data;
    out_data_t out_data;
    req_t      req;
    rsp_t      rsp;
    cmd_t      cmd;
    stat_t     stat;

    // unpack the request transaction
    always_comb begin
        in_data          = in_data_t'(s_tdata);
        req.kind         = kind_t'(s_tuser);
        req.key          = in_data.key;
        req.create       = in_data.create;
        req.exclusive    = in_data.exclusive;
        req.construct_ok = in_data.construct_ok;
        req.slot         = in_data.slot;
        req.list_room    = in_data.list_room;
    end

    ikst_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ikst_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_in    (req),
        .cmd       (cmd),
        .out_ready (m_tready),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_rsp   (rsp)
    );

    // pack the result transaction
    always_comb begin
        out_data.pad      = '0;
        out_data.used     = rsp.used;
        out_data.slot_key = rsp.slot_key;
        out_data.seq      = rsp.seq;
        out_data.slot_id  = rsp.slot_id;
        m_tdata           = out_data;
        m_tuser           = rsp.status;
        m_tlast           = rsp.last;
    end

`ifndef NO_ASSERTIONS
    // one request at a time: an accepted request closes the input side
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in flight");

    // every result other than a list item closes its run
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != STAT_LIST_ITEM)) |-> m_tlast)
        else $error("single result without last");

    // a listed or created slot implies a nonzero used count
    a_used_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && ((m_tuser == STAT_LIST_ITEM) || (m_tuser == STAT_CREATED)))
        |-> (rsp.used != '0))
        else $error("slot reported with zero used count");

    // the input side stays closed while a list run is mid-stream
    a_list_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == STAT_LIST_ITEM) && !m_tlast && m_tready) |-> !s_tready)
        else $error("input opened in the middle of a list run");
`endif

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for ipc_key_slot_table: directed and random requests,
// an in-bench slot table predictor and an in-order result scoreboard.
// Depends on ikst_pkg and ipc_key_slot_table.
module tb_top;
    import ikst_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    // Longest get scan plus output register slack.
    localparam int SETTLE_CYCLES = SLOTS + 8;

    // Slot table predictor plus the queue of results it has promised.
    class slot_table_scoreboard;
        bit                   live[SLOTS];
        logic [KEY_BITS-1:0]  keys[SLOTS];
        logic [SEQ_W-1:0]     stamps[SLOTS];
        int unsigned          high_mark;
        int unsigned          used_cnt;
        logic [SEQ_W-1:0]     next_stamp;
        rsp_t                 pending_results[$];
        int unsigned          mismatches;

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                live[i]   = 1'b0;
                keys[i]   = '0;
                stamps[i] = '0;
            end
            high_mark  = 0;
            used_cnt   = 0;
            next_stamp = '0;
            mismatches = 0;
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        function void push_result(status_t st, int unsigned id, logic [SEQ_W-1:0] sq,
                                  logic [KEY_OUT_W-1:0] k, bit lst);
            rsp_t e;
            e.status   = st;
            e.slot_id  = IDX_W'(id);
            e.seq      = sq;
            e.slot_key = k;
            e.used     = CNT_W'(used_cnt);
            e.last     = lst;
            pending_results.push_back(e);
        endfunction

        // Advance the table by one accepted request and queue its results.
        function void apply_request(req_t r);
            int unsigned pick;
            int unsigned hit;
            int unsigned n;
            bit          found;
            bit          create;
            found  = 1'b0;
            hit    = 0;
            n      = 0;
            pick   = high_mark;
            create = r.create;
            case (r.kind)
                KIND_GET: begin
                    if (r.key != '0) begin
                        for (int i = 0; i < high_mark; i++) begin
                            if (live[i] && keys[i] == r.key) begin
                                found = 1'b1;
                                hit   = i;
                                break;
                            end
                            if (!live[i] && pick == high_mark) pick = i;
                        end
                    end else begin
                        // private key never matches and always lands at the mark
                        create = 1'b1;
                    end
                    if (found) begin
                        push_result((create && r.exclusive) ? STAT_EXISTS : STAT_FOUND, hit,
                                    stamps[hit], keys[hit], 1'b1);
                    end else if (!create) begin
                        push_result(STAT_NOT_FOUND, 0, '0, r.key, 1'b1);
                    end else if (!r.construct_ok) begin
                        push_result(STAT_CONSTRUCT_NG, 0, '0, r.key, 1'b1);
                    end else if (pick >= SLOTS) begin
                        push_result(STAT_NO_SPACE, 0, '0, r.key, 1'b1);
                    end else begin
                        live[pick]   = 1'b1;
                        keys[pick]   = r.key;
                        stamps[pick] = next_stamp;
                        next_stamp   = next_stamp + 1'b1;
                        if (pick == high_mark) high_mark = high_mark + 1;
                        used_cnt = used_cnt + 1;
                        push_result(STAT_CREATED, pick, stamps[pick], r.key, 1'b1);
                    end
                end
                KIND_LIST: begin
                    if (r.list_room >= used_cnt) begin
                        for (int i = 0; i < high_mark; i++) begin
                            if (live[i]) begin
                                push_result(STAT_LIST_ITEM, i, stamps[i], keys[i], 1'b0);
                                n++;
                            end
                        end
                    end
                    if (n == 0) push_result(STAT_LIST_NONE, 0, '0, '0, 1'b1);
                    else pending_results[pending_results.size() - 1].last = 1'b1;
                end
                default: begin
                    if (r.slot >= high_mark || !live[r.slot]) begin
                        push_result(STAT_ABSENT, 0, '0, '0, 1'b1);
                    end else if (r.kind == KIND_REMOVE) begin
                        live[r.slot] = 1'b0;
                        used_cnt = used_cnt - 1;
                        push_result(STAT_REMOVED, r.slot, stamps[r.slot], keys[r.slot], 1'b1);
                    end else begin
                        push_result(STAT_FOUND, r.slot, stamps[r.slot], keys[r.slot], 1'b1);
                    end
                end
            endcase
        endfunction

        // Compare one result transaction against the oldest expectation.
        function void check_result(rsp_t got);
            rsp_t want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected result: status=%0d id=%0d seq=%h key=%h used=%0d",
                             $realtime, got.status, got.slot_id, got.seq, got.slot_key, got.used);
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status || got.slot_id !== want.slot_id ||
                got.seq !== want.seq || got.slot_key !== want.slot_key ||
                got.used !== want.used || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("[%0t] result mismatch", $realtime);
                    $display("  expected: status=%0d id=%0d seq=%h key=%h used=%0d last=%b",
                             want.status, want.slot_id, want.seq, want.slot_key, want.used,
                             want.last);
                    $display("  actual:   status=%0d id=%0d seq=%h key=%h used=%0d last=%b",
                             got.status, got.slot_id, got.seq, got.slot_key, got.used, got.last);
                end
            end
        endfunction
    endclass

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [KIND_W-1:0]     s_tuser  = KIND_GET;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  m_tlast;

    slot_table_scoreboard sb = new();

    int unsigned cycle_count = 0;
    int unsigned rx_hold     = 0;
    bit          rx_steady   = 1'b0;
    out_data_t   mon_data;
    rsp_t        mon_rsp;

    ipc_key_slot_table DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Idle length: mostly none or short, now and then a long one.
    function automatic int unsigned idle_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Pick a random valid slot below the mark, or -1 when the table is empty.
    function automatic int live_slot();
        int count;
        int k;
        count = 0;
        for (int i = 0; i < sb.high_mark; i++) if (sb.live[i]) count++;
        if (count == 0) return -1;
        k = $urandom_range(0, count - 1);
        for (int i = 0; i < sb.high_mark; i++) begin
            if (sb.live[i]) begin
                if (k == 0) return i;
                k--;
            end
        end
        return -1;
    endfunction

    function automatic req_t make_req(kind_t k, logic [KEY_BITS-1:0] key, bit create,
                                      bit excl, bit ok, logic [IDX_W-1:0] slot,
                                      logic [ROOM_W-1:0] room);
        req_t r;
        r.kind         = k;
        r.key          = key;
        r.create       = create;
        r.exclusive    = excl;
        r.construct_ok = ok;
        r.slot         = slot;
        r.list_room    = room;
        return r;
    endfunction

    // Random request steered by the current table contents; extra_removes shifts
    // weight from get to remove.
    function automatic req_t rand_request(int unsigned extra_removes);
        req_t        r;
        int unsigned roll;
        int unsigned get_w;
        int          s;
        r = make_req(KIND_GET, $urandom, $urandom_range(0, 9) < 7, $urandom_range(0, 1),
                     $urandom_range(0, 9) != 0, $urandom_range(0, SLOTS - 1),
                     $urandom_range(0, 65535));
        get_w = 45 - extra_removes;
        roll  = $urandom_range(0, 99);
        s     = live_slot();
        if (roll < get_w) begin
            roll = $urandom_range(0, 99);
            if (roll < 45 && s >= 0) r.key = sb.keys[s];
            else if (roll < 60) r.key = '0;
        end else if (roll < get_w + 40 + extra_removes && roll >= get_w + 20 + extra_removes) begin
            r.kind = KIND_QUERY;
        end else if (roll < get_w + 20 + extra_removes) begin
            r.kind = KIND_REMOVE;
        end else begin
            r.kind = KIND_LIST;
            case ($urandom_range(0, 3))
                0: r.list_room = ROOM_W'(sb.used_cnt);
                1: r.list_room = (sb.used_cnt > 0) ? ROOM_W'(sb.used_cnt - 1) : '0;
                2: r.list_room = $urandom_range(0, 70);
                default: ;
            endcase
        end
        if ((r.kind == KIND_REMOVE || r.kind == KIND_QUERY) && s >= 0 &&
            $urandom_range(0, 3) != 0)
            r.slot = IDX_W'(s);
        return r;
    endfunction

    // Present one request, hold it until accepted, then idle as chosen.
    task automatic send_request(input req_t r, input bit steady);
        in_data_t    d;
        int unsigned gap;
        d              = '0;
        d.key          = r.key;
        d.create       = r.create;
        d.exclusive    = r.exclusive;
        d.construct_ok = r.construct_ok;
        d.slot         = r.slot;
        d.list_room    = r.list_room;
        s_tdata  <= d;
        s_tuser  <= r.kind;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.apply_request(r);
        gap = steady ? 0 : idle_len();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Drop valid and hold off until every promised result has arrived.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    // Result side: stall at random, with steady stretches while rx_steady is set.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_hold != 0) begin
            m_tready <= 1'b0;
            rx_hold  <= rx_hold - 1;
        end else begin
            m_tready <= 1'b1;
            if (!rx_steady && $urandom_range(0, 99) < 25) rx_hold <= idle_len();
        end
    end

    // Monitor: every result transaction goes to the scoreboard.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            mon_data         = m_tdata;
            mon_rsp.status   = status_t'(m_tuser);
            mon_rsp.slot_id  = mon_data.slot_id;
            mon_rsp.seq      = mon_data.seq;
            mon_rsp.slot_key = mon_data.slot_key;
            mon_rsp.used     = mon_data.used;
            mon_rsp.last     = m_tlast;
            sb.check_result(mon_rsp);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        req_t        r;
        int unsigned tries;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty table, lookups, creation paths, removal and list rooms.
        send_request(make_req(KIND_LIST, '0, 0, 0, 0, '0, 16'hFFFF), 1'b0);
        send_request(make_req(KIND_QUERY, '0, 0, 0, 0, 6'd0, '0), 1'b0);
        send_request(make_req(KIND_REMOVE, '0, 1, 1, 1, 6'd63, '0), 1'b0);
        send_request(make_req(KIND_GET, 32'hFFFF_FFFF, 0, 0, 1, '0, '0), 1'b0);
        send_request(make_req(KIND_GET, 32'hFFFF_FFFF, 1, 0, 0, '0, '0), 1'b0);
        send_request(make_req(KIND_GET, 32'hFFFF_FFFF, 1, 0, 1, '0, '0), 1'b0);
        send_request(make_req(KIND_GET, 32'hFFFF_FFFF, 0, 1, 1, '0, '0), 1'b0);
        send_request(make_req(KIND_GET, 32'hFFFF_FFFF, 1, 1, 1, '0, '0), 1'b0);
        send_request(make_req(KIND_GET, 32'hFFFF_FFFF, 1, 0, 1, '0, '0), 1'b0);
        send_request(make_req(KIND_GET, '0, 0, 0, 1, '0, '0), 1'b0);
        send_request(make_req(KIND_GET, '0, 1, 0, 0, '0, '0), 1'b0);
        send_request(make_req(KIND_GET, 32'h0000_0001, 1, 0, 1, '0, '0), 1'b0);
        send_request(make_req(KIND_GET, 32'h8000_0000, 1, 1, 1, '0, '0), 1'b0);
        send_request(make_req(KIND_QUERY, '0, 0, 0, 0, 6'd2, '0), 1'b0);
        send_request(make_req(KIND_REMOVE, '0, 0, 0, 0, 6'd1, '0), 1'b0);
        send_request(make_req(KIND_REMOVE, '0, 0, 0, 0, 6'd1, '0), 1'b0);
        send_request(make_req(KIND_QUERY, '0, 0, 0, 0, 6'd40, '0), 1'b0);
        send_request(make_req(KIND_LIST, '0, 0, 0, 0, '0, 16'd0), 1'b0);
        send_request(make_req(KIND_LIST, '0, 0, 0, 0, '0, 16'hFFFF), 1'b0);
        send_request(make_req(KIND_LIST, '0, 0, 0, 0, '0, 16'd3), 1'b0);
        send_request(make_req(KIND_LIST, '0, 0, 0, 0, '0, 16'd2), 1'b0);
        send_request(make_req(KIND_GET, 32'h5A5A_5A5A, 1, 0, 1, '0, '0), 1'b0);
        send_request(make_req(KIND_GET, '0, 1, 1, 1, '0, '0), 1'b0);
        send_request(make_req(KIND_QUERY, 32'hFFFF_FFFF, 1, 1, 1, 6'd63, 16'hFFFF), 1'b0);

        // Hold the sender until the table is quiet before the random mix.
        wait_drained();
        repeat (70) send_request(rand_request(0), 1'b0);

        // Fill the table back to back, then push past full.
        wait_drained();
        rx_steady = 1'b1;
        tries = 0;
        while (sb.used_cnt < SLOTS && tries < 100) begin
            r = rand_request(0);
            r.kind = KIND_GET;
            r.create = 1'b1;
            r.construct_ok = ($urandom_range(0, 9) != 0);
            if ($urandom_range(0, 4) == 0) r.key = '0;
            send_request(r, 1'b1);
            tries++;
        end
        rx_steady = 1'b0;
        repeat (3) send_request(make_req(KIND_GET, $urandom, 1, 0, 1, '0, '0), 1'b0);
        send_request(make_req(KIND_GET, '0, 1, 0, 1, '0, '0), 1'b0);
        send_request(make_req(KIND_LIST, '0, 0, 0, 0, '0, ROOM_W'(sb.used_cnt)), 1'b0);
        send_request(make_req(KIND_LIST, '0, 0, 0, 0, '0, ROOM_W'(sb.used_cnt - 1)), 1'b0);
        send_request(make_req(KIND_QUERY, '0, 0, 0, 0, 6'd63, '0), 1'b0);

        // Thin the table out with removes weighted up, mixing in refills.
        repeat (55) send_request(rand_request(25), 1'b0);
        send_request(make_req(KIND_LIST, '0, 0, 0, 0, '0, 16'hFFFF), 1'b0);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
